[hw/rtl/spa_pkg.sv]
package spa_pkg;

  localparam int unsigned DEPTH_DEF         = 64;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

  localparam logic OP_ALLOC = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request word
    logic dec_pop;    // take free-list head, read its next link
    logic dec_new;    // take the next never-used slot
    logic dec_free;   // read all entries of the requested slot
    logic set_fail;
    logic pop_free;   // free head <= next link just read
    logic link_new;   // write new slot, push onto allocated list
    logic back_link;  // old allocated head points back to new slot
    logic unlink;     // patch neighbors of the slot being freed
    logic self_free;  // clear slot, push onto free list
    logic load_out;
  } spa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic free_avail;
    logic hw_avail;
    logic idx_ok;
    logic slot_alloc;
    logic used_nonempty;
  } spa_sts_t;

endpackage

[hw/rtl/spa_ram.sv]
module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/spa_ctrl.sv]
module spa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  spa_pkg::spa_sts_t sts,
  output spa_pkg::spa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_LINK,
    S_BACK,
    S_CHECK,
    S_SELF,
    S_RESP
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == spa_pkg::OP_ALLOC) begin
          if (sts.free_avail) begin
            cmd.dec_pop = 1'b1;
            state_next  = S_POP;
          end else if (sts.hw_avail) begin
            cmd.dec_new = 1'b1;
            state_next  = S_LINK;
          end else begin
            cmd.set_fail = 1'b1;
            state_next   = S_RESP;
          end
        end else begin
          if (sts.idx_ok) begin
            cmd.dec_free = 1'b1;
            state_next   = S_CHECK;
          end else begin
            cmd.set_fail = 1'b1;
            state_next   = S_RESP;
          end
        end
      end
      S_POP: begin
        cmd.pop_free = 1'b1;
        state_next   = S_LINK;
      end
      S_LINK: begin
        cmd.link_new = 1'b1;
        state_next   = sts.used_nonempty ? S_BACK : S_RESP;
      end
      S_BACK: begin
        cmd.back_link = 1'b1;
        state_next    = S_RESP;
      end
      S_CHECK: begin
        if (sts.slot_alloc) begin
          cmd.unlink = 1'b1;
          state_next = S_SELF;
        end else begin
          cmd.set_fail = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_SELF: begin
        cmd.self_free = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        // output register frees up this cycle or is already empty
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/spa_dp.sv]
module spa_dp #(
  parameter int unsigned DEPTH         = spa_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = spa_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spa_pkg::spa_cmd_t        cmd,
  output spa_pkg::spa_sts_t        sts,
  input  logic                     operation,
  input  logic [PAYLOAD_WIDTH-1:0] payload_in,
  input  logic [$clog2(DEPTH)-1:0] slot_index,
  output logic                     ok,
  output logic [$clog2(DEPTH)-1:0] granted_index,
  output logic [PAYLOAD_WIDTH-1:0] payload_out
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  // null link
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  logic                     op_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [IW-1:0]            idx_r;

  logic [LW-1:0] free_head;
  logic [LW-1:0] used_head;
  logic [LW-1:0] high_water;

  logic [IW-1:0] slot;
  logic [LW-1:0] link_a;

  logic                     res_ok;
  logic [IW-1:0]            res_idx;
  logic [PAYLOAD_WIDTH-1:0] res_pay;

  logic [IW-1:0] raddr;

  logic                     nxt_we, prv_we, st_we, pl_we;
  logic [IW-1:0]            nxt_wa, prv_wa;
  logic [LW-1:0]            nxt_wd, prv_wd;
  logic                     st_wd;
  logic [LW-1:0]            nxt_rd, prv_rd;
  logic                     st_rd;
  logic [PAYLOAD_WIDTH-1:0] pl_rd;

  assign sts.op            = op_r;
  assign sts.free_avail    = (free_head != NIL);
  assign sts.hw_avail      = (high_water != NIL);
  assign sts.idx_ok        = (LW'(idx_r) < high_water);
  assign sts.slot_alloc    = st_rd;
  assign sts.used_nonempty = (used_head != NIL);

  assign raddr = cmd.dec_pop ? free_head[IW-1:0] : idx_r;

  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = slot;
    nxt_wd = used_head;
    prv_we = 1'b0;
    prv_wa = slot;
    prv_wd = NIL;
    st_we  = 1'b0;
    st_wd  = 1'b0;
    pl_we  = 1'b0;
    if (cmd.link_new) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
      st_we  = 1'b1;
      st_wd  = 1'b1;
      pl_we  = 1'b1;
    end
    if (cmd.back_link) begin
      prv_we = 1'b1;
      prv_wa = link_a[IW-1:0];
      prv_wd = LW'(slot);
    end
    if (cmd.unlink) begin
      // prev.next = next ; next.prev = prev
      nxt_we = (prv_rd != NIL);
      nxt_wa = prv_rd[IW-1:0];
      nxt_wd = nxt_rd;
      prv_we = (nxt_rd != NIL);
      prv_wa = nxt_rd[IW-1:0];
      prv_wd = prv_rd;
    end
    if (cmd.self_free) begin
      nxt_we = 1'b1;
      nxt_wd = free_head;
      prv_we = 1'b1;
      st_we  = 1'b1;
    end
  end

  spa_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(raddr), .rdata(nxt_rd)
  );

  spa_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(raddr), .rdata(prv_rd)
  );

  spa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_status (
    .clk(clk), .we(st_we), .waddr(slot), .wdata(st_wd), .raddr(raddr), .rdata(st_rd)
  );

  spa_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(DEPTH)) u_payload (
    .clk(clk), .we(pl_we), .waddr(slot), .wdata(pay_r), .raddr(raddr), .rdata(pl_rd)
  );

  // list heads and high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= NIL;
      used_head  <= NIL;
      high_water <= '0;
    end else begin
      if (cmd.dec_new) begin
        high_water <= high_water + 1'b1;
      end
      if (cmd.pop_free) begin
        free_head <= nxt_rd;
      end
      if (cmd.link_new) begin
        used_head <= LW'(slot);
      end
      if (cmd.unlink && (prv_rd == NIL)) begin
        used_head <= nxt_rd;
      end
      if (cmd.self_free) begin
        free_head <= LW'(slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= operation;
      pay_r <= payload_in;
      idx_r <= slot_index;
    end
    if (cmd.dec_pop) begin
      slot <= free_head[IW-1:0];
    end
    if (cmd.dec_new) begin
      slot <= high_water[IW-1:0];
    end
    if (cmd.dec_free) begin
      slot <= idx_r;
    end
    if (cmd.set_fail) begin
      res_ok  <= 1'b0;
      res_idx <= '0;
      res_pay <= '0;
    end
    if (cmd.link_new) begin
      link_a  <= used_head;
      res_ok  <= 1'b1;
      res_idx <= slot;
      res_pay <= '0;
    end
    if (cmd.unlink) begin
      res_pay <= pl_rd;
    end
    if (cmd.self_free) begin
      res_ok  <= 1'b1;
      res_idx <= '0;
    end
    if (cmd.load_out) begin
      ok            <= res_ok;
      granted_index <= res_idx;
      payload_out   <= res_pay;
    end
  end

endmodule

[hw/rtl/slot_pool_allocator.sv]
// States after decode: result on a full pool or out-of-range free; check,
// result on freeing an unused slot; pop (free list nonempty), link, back link
// (used list nonempty), result on an allocate; check, unlink, self free, result on a
// free. One request at a time; each link memory has one write port, so the two link
// writes of an allocate or free take separate cycles. Reset (rst, synchronous) empties
// both lists and clears the high-water mark; the slot memories need no clearing.
module slot_pool_allocator #(
  parameter int unsigned DEPTH         = spa_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = spa_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     operation,
  input  logic [PAYLOAD_WIDTH-1:0] payload_in,
  input  logic [$clog2(DEPTH)-1:0] slot_index,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic                     ok,
  output logic [$clog2(DEPTH)-1:0] granted_index,
  output logic [PAYLOAD_WIDTH-1:0] payload_out
);

  spa_pkg::spa_cmd_t cmd;
  spa_pkg::spa_sts_t sts;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  spa_dp #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .payload_in    (payload_in),
    .slot_index    (slot_index),
    .ok            (ok),
    .granted_index (granted_index),
    .payload_out   (payload_out)
  );

endmodule

[hw/rtl/spa_checker.sv]
module spa_checker #(
  parameter int unsigned DEPTH         = spa_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = spa_pkg::PAYLOAD_WIDTH_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_stall,
  input logic                     rsp_valid,
  input logic                     rsp_stall,
  input logic                     ok,
  input logic [$clog2(DEPTH)-1:0] granted_index,
  input logic [PAYLOAD_WIDTH-1:0] payload_out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(ok) && $stable(granted_index) && $stable(payload_out)))
    else $error("stalled result word changed or dropped");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous one still in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> ((granted_index == '0) && (payload_out == '0)))
    else $error("failed result carries nonzero fields");

endmodule

bind slot_pool_allocator spa_checker #(
  .DEPTH         (DEPTH),
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_spa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_stall     (req_stall),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .ok            (ok),
  .granted_index (granted_index),
  .payload_out   (payload_out)
);

[test/slot_pool_allocator_checker.sv]
`timescale 1ns / 1ps
module slot_pool_allocator_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     req_valid,
  input  logic                                     req_stall,
  input  logic                                     operation,
  input  logic [spa_pkg::PAYLOAD_WIDTH_DEF-1:0]    payload_in,
  input  logic [$clog2(spa_pkg::DEPTH_DEF)-1:0]    slot_index,
  input  logic                                     rsp_valid,
  input  logic                                     rsp_stall,
  input  logic                                     ok,
  input  logic [$clog2(spa_pkg::DEPTH_DEF)-1:0]    granted_index,
  input  logic [spa_pkg::PAYLOAD_WIDTH_DEF-1:0]    payload_out,
  output int                                       errors,
  output int                                       pending,
  output int                                       grants,
  output int                                       releases,
  output int                                       full_rejects,
  output int                                       bad_frees
);

  localparam int unsigned DEPTH = spa_pkg::DEPTH_DEF;
  localparam int unsigned PW    = spa_pkg::PAYLOAD_WIDTH_DEF;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam logic [IW:0] NIL   = (IW+1)'(DEPTH);

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] slot;
    logic [PW-1:0] data;
  } outcome_t;

  // shadow of the pool
  logic          in_use   [DEPTH];
  logic [IW:0]   fwd_link [DEPTH];
  logic [IW:0]   back_link[DEPTH];
  logic [PW-1:0] contents [DEPTH];
  logic [IW:0]   free_top;
  logic [IW:0]   used_top;
  logic [IW:0]   high_mark;

  outcome_t outcome_q[$];
  outcome_t want;
  int       n_err;

  initial begin
    errors       = 0;
    pending      = 0;
    grants       = 0;
    releases     = 0;
    full_rejects = 0;
    bad_frees    = 0;
    n_err        = 0;
  end

  function automatic outcome_t apply_request(logic op, logic [PW-1:0] data,
                                             logic [IW-1:0] idx);
    outcome_t    res;
    logic [IW:0] slot;
    logic [IW:0] prv;
    logic [IW:0] nxt;
    res = '0;
    if (op == spa_pkg::OP_ALLOC) begin
      if (free_top != NIL) begin
        slot     = free_top;
        free_top = fwd_link[slot[IW-1:0]];
      end else if (high_mark != NIL) begin
        slot      = high_mark;
        high_mark = high_mark + 1'b1;
      end else begin
        full_rejects++;
        return res;
      end
      if (used_top != NIL) back_link[used_top[IW-1:0]] = slot;
      fwd_link[slot[IW-1:0]]  = used_top;
      back_link[slot[IW-1:0]] = NIL;
      in_use[slot[IW-1:0]]    = 1'b1;
      contents[slot[IW-1:0]]  = data;
      used_top = slot;
      res.ok   = 1'b1;
      res.slot = slot[IW-1:0];
      grants++;
    end else begin
      // slots at or above the high mark were never written
      if ({1'b0, idx} >= high_mark || !in_use[idx]) begin
        bad_frees++;
        return res;
      end
      prv = back_link[idx];
      nxt = fwd_link[idx];
      if (prv != NIL) fwd_link[prv[IW-1:0]] = nxt;
      else used_top = nxt;
      if (nxt != NIL) back_link[nxt[IW-1:0]] = prv;
      in_use[idx]    = 1'b0;
      back_link[idx] = NIL;
      fwd_link[idx]  = free_top;
      free_top       = {1'b0, idx};
      res.ok   = 1'b1;
      res.data = contents[idx];
      releases++;
    end
    return res;
  endfunction

  task automatic note_miss(string what, logic [63:0] exp_v, logic [63:0] got_v);
    n_err++;
    if (n_err <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        in_use[i]    = 1'b0;
        fwd_link[i]  = NIL;
        back_link[i] = NIL;
        contents[i]  = '0;
      end
      free_top  = NIL;
      used_top  = NIL;
      high_mark = '0;
      outcome_q.delete();
    end else begin
      // result first: a word accepted this edge cannot answer yet
      if (rsp_valid && !rsp_stall) begin
        if (outcome_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: result word with nothing outstanding (ok=%b idx=%0d data=%0h)",
                     $realtime, ok, granted_index, payload_out);
        end else begin
          want = outcome_q.pop_front();
          if (ok !== want.ok) note_miss("ok", want.ok, ok);
          if (granted_index !== want.slot) note_miss("granted_index", want.slot, granted_index);
          if (payload_out !== want.data) note_miss("payload_out", want.data, payload_out);
        end
      end
      if (req_valid && !req_stall)
        outcome_q.push_back(apply_request(operation, payload_in, slot_index));
    end
    errors  <= n_err;
    pending <= outcome_q.size();
  end

endmodule

[test/slot_pool_allocator_tb.sv]
`timescale 1ns / 1ps
module slot_pool_allocator_tb;

  localparam int unsigned IW      = $clog2(spa_pkg::DEPTH_DEF);
  localparam int unsigned PW      = spa_pkg::PAYLOAD_WIDTH_DEF;
  localparam logic        OP_FREE = ~spa_pkg::OP_ALLOC;
  localparam int          TOTAL   = 1700;

  logic          clk           = 1'b0;
  logic          rst           = 1'b1;
  logic          req_valid     = 1'b0;
  logic          operation     = spa_pkg::OP_ALLOC;
  logic [PW-1:0] payload_in    = '0;
  logic [IW-1:0] slot_index    = '0;
  logic          rsp_stall     = 1'b0;
  logic          req_stall;
  logic          rsp_valid;
  logic          ok;
  logic [IW-1:0] granted_index;
  logic [PW-1:0] payload_out;

  int errors, pending, grants, releases, full_rejects, bad_frees;
  int sent = 0;
  bit calm = 1'b0;  // no gaps on either side while set

  always #2 clk = ~clk;

  slot_pool_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .payload_in   (payload_in),
    .slot_index   (slot_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .granted_index(granted_index),
    .payload_out  (payload_out)
  );

  slot_pool_allocator_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .payload_in   (payload_in),
    .slot_index   (slot_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .ok           (ok),
    .granted_index(granted_index),
    .payload_out  (payload_out),
    .errors       (errors),
    .pending      (pending),
    .grants       (grants),
    .releases     (releases),
    .full_rejects (full_rejects),
    .bad_frees    (bad_frees)
  );

  // valid stays high across back-to-back words; lowered only before a gap
  task automatic send(input logic op, input logic [PW-1:0] data, input logic [IW-1:0] idx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= op;
    payload_in <= data;
    slot_index <= idx;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  task automatic grab(input logic [PW-1:0] data);
    send(spa_pkg::OP_ALLOC, data, IW'($urandom_range(0, 2**IW - 1)));
  endtask

  task automatic drop(input logic [IW-1:0] idx);
    send(OP_FREE, $urandom(), idx);
  endtask

  // result side stall
  initial begin
    int hold;
    wait (!rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin
    int run;
    int pct;
    int mix[4];
    bit first;
    mix   = '{10, 40, 60, 90};
    first = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    drop(0);                 // nothing used yet
    drop('1);
    grab('0);                // slot 0, empty used list
    grab('1);                // slot 1, back link to 0
    grab(32'hA5A5_A5A5);     // slot 2
    drop(1);                 // middle of used list
    drop(1);                 // already free
    drop(3);                 // above high mark
    drop(2);                 // head of used list
    drop(0);                 // last one, list empties
    grab(32'h5A5A_5A5A);     // reuses free head
    grab(32'h8000_0001);
    grab(32'h7FFF_FFFE);
    grab($urandom());        // free list empty again, new slot
    drop(3);
    drop(0);
    drop(63);

    while (sent < TOTAL) begin
      // first phase fills the pool past full
      run   = first ? 90 : $urandom_range(40, 150);
      pct   = first ? 100 : mix[$urandom_range(0, 3)];
      calm  = !first && ($urandom_range(0, 3) == 0);
      first = 1'b0;
      repeat (run) begin
        if ($urandom_range(1, 100) <= pct) grab($urandom());
        else drop(IW'($urandom_range(0, 2**IW - 1)));
      end
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    // pending counts the last accepted word only after this edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("%0d request words sent: %0d slots granted, %0d freed", sent, grants, releases);
    $display("%0d allocates refused on a full pool, %0d frees refused", full_rejects,
             bad_frees);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d result words outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/spa_pkg.sv
hw/rtl/spa_ram.sv
hw/rtl/spa_ctrl.sv
hw/rtl/spa_dp.sv
hw/rtl/slot_pool_allocator.sv
hw/rtl/spa_checker.sv
test/slot_pool_allocator_checker.sv
test/slot_pool_allocator_tb.sv
